@@ hdl/acpis5_pkg.sv @@
// ----------------------------------------------------------------------------
// acpis5_pkg
// Opcodes, name characters and parse phases for the _S5_ sleep type parser.
// ----------------------------------------------------------------------------
package acpis5_pkg;

    localparam logic [7:0] NAME_OP     = 8'h08;
    localparam logic [7:0] ROOT_CHAR   = 8'h5C;
    localparam logic [7:0] PACKAGE_OP  = 8'h12;
    localparam logic [7:0] BYTE_PREFIX = 8'h0A;
    localparam logic [7:0] LEN_MASK    = 8'hC0;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_5      = 8'h35;
    localparam logic [15:0] SLP_ENABLE = 16'h2000;
    localparam int HIST_DEPTH          = 6;

    typedef enum logic [2:0] {
        PH_SCAN        = 3'd0,
        PH_PKG_OP      = 3'd1,
        PH_LEAD        = 3'd2,
        PH_SKIP        = 3'd3,
        PH_ELEM_PREFIX = 3'd4,
        PH_ELEM_VALUE  = 3'd5,
        PH_DONE_FOUND  = 3'd6,
        PH_DONE_MISS   = 3'd7
    } phase_t;

    function automatic logic [15:0] control_word(input logic [7:0] t);
        control_word = {t[5:0], 10'b0} | SLP_ENABLE;
    endfunction

endpackage

@@ hdl/acpi_s5_sleep_type_extract_unit.sv @@
// ----------------------------------------------------------------------------
// acpi_s5_sleep_type_extract_unit
// Scans a DSDT body byte stream for the first _S5_ package and reports its
// two sleep type elements, or a miss at the last byte of the table.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    table_byte, last_byte
//  output    out_valid / out_ready  found, sleep_type_a, sleep_type_b,
//                                   control_word_a, control_word_b
//
//  One byte is taken every cycle while the input is not stalled; a request goes
//  from the input register to the result register through the phase and history update.
//  The input register holds one more request while a result waits, so the
//  input stalls only when both registers are full.
//  Reset clears the history, the phase and both valid flags.
// ----------------------------------------------------------------------------
module acpi_s5_sleep_type_extract_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  table_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [7:0]  sleep_type_a,
    output logic [7:0]  sleep_type_b,
    output logic [15:0] control_word_a,
    output logic [15:0] control_word_b
);
    import acpis5_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic [7:0] hist_reg [HIST_DEPTH];
    phase_t     phase_reg, phase_next;
    logic [2:0] skip_reg, skip_next;
    logic [7:0] cap_a_reg, cap_a_next;

    logic       out_valid_reg;
    logic       found_reg;
    logic [7:0] type_a_reg;
    logic [7:0] type_b_reg;

    logic       advance;
    logic       emit_found;
    logic       emit_miss;
    logic       prefix_ok;
    logic       name_hit;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign name_hit = (hist_reg[3] == CHAR_UNDER) && (hist_reg[4] == CHAR_S) &&
                      (hist_reg[5] == CHAR_5) && (byte_reg == CHAR_UNDER);
    assign prefix_ok = (hist_reg[2] == NAME_OP) ||
                       ((hist_reg[1] == NAME_OP) && (hist_reg[2] == ROOT_CHAR));

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        cap_a_next = cap_a_reg;
        emit_found = 1'b0;
        case (phase_reg)
            PH_SCAN:
            begin
                if (name_hit)
                begin
                    phase_next = prefix_ok ? PH_PKG_OP : PH_DONE_MISS;
                end
            end
            PH_PKG_OP:
            begin
                phase_next = (byte_reg == PACKAGE_OP) ? PH_LEAD : PH_DONE_MISS;
            end
            PH_LEAD:
            begin
                skip_next  = {1'b0, byte_reg[7:6] & LEN_MASK[7:6]} + 3'd1;
                phase_next = PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 3'd1;
                if (skip_next == 3'd0)
                begin
                    phase_next = PH_ELEM_PREFIX;
                end
            end
            PH_ELEM_PREFIX, PH_ELEM_VALUE:
            begin
                if (phase_reg == PH_ELEM_PREFIX && byte_reg == BYTE_PREFIX)
                begin
                    phase_next = PH_ELEM_VALUE;
                end
                else if (skip_reg == 3'd0)
                begin
                    cap_a_next = byte_reg;
                    skip_next  = 3'd1;
                    phase_next = PH_ELEM_PREFIX;
                end
                else
                begin
                    emit_found = 1'b1;
                    skip_next  = 3'd0;
                    phase_next = PH_DONE_FOUND;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign emit_miss = last_reg && !emit_found && (phase_next != PH_DONE_FOUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= table_byte;
            last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= 8'h00;
            end
            phase_reg <= PH_SCAN;
            skip_reg  <= 3'd0;
            cap_a_reg <= 8'h00;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= 8'h00;
                end
                phase_reg <= PH_SCAN;
                skip_reg  <= 3'd0;
                cap_a_reg <= 8'h00;
            end
            else
            begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                end
                hist_reg[HIST_DEPTH - 1] <= byte_reg;
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                cap_a_reg <= cap_a_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit_found || emit_miss;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (emit_found || emit_miss))
        begin
            found_reg  <= emit_found;
            type_a_reg <= emit_found ? cap_a_reg : 8'h00;
            type_b_reg <= emit_found ? byte_reg : 8'h00;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign sleep_type_a   = type_a_reg;
    assign sleep_type_b   = type_b_reg;
    assign control_word_a = found_reg ? control_word(type_a_reg) : 16'h0000;
    assign control_word_b = found_reg ? control_word(type_b_reg) : 16'h0000;

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> type_a_reg == 8'h00 && type_b_reg == 8'h00)
        else $error("miss result carries nonzero sleep types");

    a_last_rearm : assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> phase_reg == PH_SCAN && hist_reg[5] == 8'h00)
        else $error("last byte did not rearm the parser");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a waiting result");

    a_skip_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 3'd0)
        else $error("skip phase with empty skip count");

    a_last_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg && phase_reg != PH_DONE_FOUND |=> out_valid_reg)
        else $error("table ended without a result");

endmodule

@@ tb/sv/tb_acpi_s5_sleep_type_extract_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_acpi_s5_sleep_type_extract_unit
// Drives DSDT body byte streams into the _S5_ sleep type parser, with random
// idle bursts on both channels, and checks every result field against a local
// parse model and a short table of hand-written cases.
// ----------------------------------------------------------------------------
module tb_acpi_s5_sleep_type_extract_unit;

    import acpis5_pkg::*;

    typedef struct packed {
        logic        found;
        logic [7:0]  sleep_a;
        logic [7:0]  sleep_b;
        logic [15:0] ctrl_a;
        logic [15:0] ctrl_b;
    } s5_result_t;

    typedef struct {
        logic [7:0] tbyte;
        logic       tlast;
        bit         typed;
        s5_result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  table_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic [7:0]  sleep_type_a;
    logic [7:0]  sleep_type_b;
    logic [15:0] control_word_a;
    logic [15:0] control_word_b;

    logic [7:0]  hist [HIST_DEPTH];
    phase_t      ph;
    logic [2:0]  skip_cnt;
    logic [7:0]  held_type_a;

    s5_result_t  pending_results [$];
    stim_row_t   directed_rows [$];
    s5_result_t  got_result;
    s5_result_t  want_result;
    int          error_count = 0;
    int          parsed_count = 0;
    bit          quiet = 1'b0;

    acpi_s5_sleep_type_extract_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .table_byte     (table_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .sleep_type_a   (sleep_type_a),
        .sleep_type_b   (sleep_type_b),
        .control_word_a (control_word_a),
        .control_word_b (control_word_b)
    );

    always #4 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            flag_error($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    function automatic logic [15:0] sleep_ctrl(input logic [7:0] t);
        logic [15:0] wide;
        wide = {8'h00, t};
        return (wide << 10) | SLP_ENABLE;
    endfunction

    task automatic clear_parse_state();
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist[i] = 8'h00;
        end
        ph = PH_SCAN;
        skip_cnt = 3'd0;
        held_type_a = 8'h00;
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic is_last,
                              output bit emit, output s5_result_t r);
        bit has_prefix;
        emit = 1'b0;
        r = '0;
        case (ph)
            PH_SCAN:
            begin
                if (hist[3] == CHAR_UNDER && hist[4] == CHAR_S && hist[5] == CHAR_5 &&
                    c == CHAR_UNDER)
                begin
                    has_prefix = (hist[2] == NAME_OP) ||
                                 (hist[1] == NAME_OP && hist[2] == ROOT_CHAR);
                    ph = has_prefix ? PH_PKG_OP : PH_DONE_MISS;
                end
            end
            PH_PKG_OP:
            begin
                ph = (c == PACKAGE_OP) ? PH_LEAD : PH_DONE_MISS;
            end
            PH_LEAD:
            begin
                skip_cnt = 3'((c & LEN_MASK) >> 6) + 3'd1;
                ph = PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_cnt = skip_cnt - 3'd1;
                if (skip_cnt == 3'd0)
                begin
                    ph = PH_ELEM_PREFIX;
                end
            end
            PH_ELEM_PREFIX, PH_ELEM_VALUE:
            begin
                if (ph == PH_ELEM_PREFIX && c == BYTE_PREFIX)
                begin
                    ph = PH_ELEM_VALUE;
                end
                else if (skip_cnt == 3'd0)
                begin
                    held_type_a = c;
                    skip_cnt = 3'd1;
                    ph = PH_ELEM_PREFIX;
                end
                else
                begin
                    emit = 1'b1;
                    r.found = 1'b1;
                    r.sleep_a = held_type_a;
                    r.sleep_b = c;
                    r.ctrl_a = sleep_ctrl(held_type_a);
                    r.ctrl_b = sleep_ctrl(c);
                    skip_cnt = 3'd0;
                    ph = PH_DONE_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < HIST_DEPTH - 1; i++)
        begin
            hist[i] = hist[i + 1];
        end
        hist[HIST_DEPTH - 1] = c;
        if (is_last)
        begin
            if (!emit && ph != PH_DONE_FOUND)
            begin
                emit = 1'b1;
                r = '0;
            end
            clear_parse_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input s5_result_t typed_res);
        bit         emit;
        s5_result_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        table_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        parsed_count++;
        parse_byte(b, l, emit, r);
        if (typed)
        begin
            pending_results.push_back(typed_res);
        end
        else if (emit)
        begin
            pending_results.push_back(r);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic l, input bit typed = 1'b0,
                           input logic f = 1'b0, input logic [7:0] a = 8'h00,
                           input logic [7:0] bb = 8'h00, input logic [15:0] cwa = 16'h0,
                           input logic [15:0] cwb = 16'h0);
        stim_row_t row;
        row.tbyte = b;
        row.tlast = l;
        row.typed = typed;
        row.res = '{found: f, sleep_a: a, sleep_b: bb, ctrl_a: cwa, ctrl_b: cwb};
        directed_rows.push_back(row);
    endtask

    task automatic send_table();
        logic [7:0] body [$];
        logic [7:0] lead;
        int         cut;
        s5_result_t none;
        none = '0;
        repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 4))
                0, 1: body.push_back(NAME_OP);
                2, 3:
                begin
                    body.push_back(NAME_OP);
                    body.push_back(ROOT_CHAR);
                end
                default: body.push_back(8'($urandom));
            endcase
            body.push_back(CHAR_UNDER);
            body.push_back(CHAR_S);
            body.push_back(CHAR_5);
            body.push_back(CHAR_UNDER);
            body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : PACKAGE_OP);
            lead = 8'($urandom);
            body.push_back(lead);
            repeat (lead[7:6]) body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            repeat (2)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    body.push_back(BYTE_PREFIX);
                end
                case ($urandom_range(0, 5))
                    0: body.push_back(8'h00);
                    1: body.push_back(8'hFF);
                    default: body.push_back(8'($urandom));
                endcase
            end
            repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, body.size());
                while (body.size() > cut)
                begin
                    void'(body.pop_back());
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
        end
        for (int i = 0; i < body.size(); i++)
        begin
            send_byte(body[i], i == body.size() - 1, 1'b0, none);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_result = '{found: found, sleep_a: sleep_type_a, sleep_b: sleep_type_b,
                           ctrl_a: control_word_a, ctrl_b: control_word_b};
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result %h", got_result));
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("found", 16'(got_result.found), 16'(want_result.found));
                check_field("sleep_type_a", 16'(got_result.sleep_a), 16'(want_result.sleep_a));
                check_field("sleep_type_b", 16'(got_result.sleep_b), 16'(want_result.sleep_b));
                check_field("control_word_a", got_result.ctrl_a, want_result.ctrl_a);
                check_field("control_word_b", got_result.ctrl_b, want_result.ctrl_b);
            end
        end
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clear_parse_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A one-byte table right after reset reports a miss.
        add_row(8'hFF, 1'b1, 1'b1);
        // Root-prefixed name, four skipped bytes, capture on the last byte.
        add_row(NAME_OP, 1'b0);
        add_row(ROOT_CHAR, 1'b0);
        add_row(CHAR_UNDER, 1'b0);
        add_row(CHAR_S, 1'b0);
        add_row(CHAR_5, 1'b0);
        add_row(CHAR_UNDER, 1'b0);
        add_row(PACKAGE_OP, 1'b0);
        add_row(8'hC0, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(BYTE_PREFIX, 1'b0);
        add_row(8'h00, 1'b1, 1'b1, 1'b1, 8'hFF, 8'h00, 16'hFC00, 16'h2000);
        // A name at the very start of the body has no prefix byte.
        add_row(CHAR_UNDER, 1'b0);
        add_row(CHAR_S, 1'b0);
        add_row(CHAR_5, 1'b0);
        add_row(CHAR_UNDER, 1'b0);
        add_row(8'h00, 1'b1, 1'b1);
        // A good prefix without the package opcode after the name.
        add_row(NAME_OP, 1'b0);
        add_row(CHAR_UNDER, 1'b0);
        add_row(CHAR_S, 1'b0);
        add_row(CHAR_5, 1'b0);
        add_row(CHAR_UNDER, 1'b0);
        add_row(BYTE_PREFIX, 1'b1, 1'b1);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].tbyte, directed_rows[i].tlast,
                      directed_rows[i].typed, directed_rows[i].res);
        end
        drain_results();

        parsed_count = 0;
        while (parsed_count < 520)
        begin
            if (parsed_count >= 450)
            begin
                quiet = 1'b1;
            end
            send_table();
        end
        drain_results();
        repeat (10) @(posedge clk);

        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
